### src/cfb_pkg.sv
package cfb_pkg;

  localparam int FRAME_BYTES    = 64;
  localparam int MAX_DATA_BYTES = 8;

  localparam logic [5:0]  DATA_BASE = 6'h12;
  localparam logic [5:0]  SPAN_BASE = 6'h04;
  localparam logic [5:0]  LAST_OFF  = 6'(FRAME_BYTES - 1);
  localparam logic [3:0]  MAX_COUNT = 4'(MAX_DATA_BYTES);
  localparam logic [7:0]  PLEN_BASE = 8'h0C;
  localparam logic [7:0]  SYNC_HI   = 8'hFF;
  localparam logic [7:0]  SYNC_LO   = 8'hFE;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'h1021;

  // latched command, shared by the sequencer and the byte mux
  typedef struct packed {
    logic [15:0] id;
    logic [3:0]  count;
    logic [63:0] data;
    logic        big_endian;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CRC  = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

endpackage

### src/cfb_crc_unit.sv
module cfb_crc_unit
  import cfb_pkg::*;
(
  input  logic        clk,
  input  logic        init,
  input  logic        en,
  input  logic [7:0]  din,
  output logic [15:0] crc
);

  logic [15:0] crc_next;

  // one byte per cycle while en is high, msb first
  always_comb begin
    logic [15:0] acc;
    acc = crc ^ {din, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (acc[15]) acc = {acc[14:0], 1'b0} ^ CRC_POLY;
      else         acc = {acc[14:0], 1'b0};
    end
    crc_next = acc;
  end

  always_ff @(posedge clk) begin
    if (init) begin
      crc <= CRC_INIT;
    end else if (en) begin
      crc <= crc_next;
    end
  end

endmodule

### src/cfb_byte_mux.sv
module cfb_byte_mux
  import cfb_pkg::*;
(
  input  cmd_t        cmd,
  input  logic [5:0]  offset,
  input  logic [15:0] crc,
  output logic [7:0]  byte_out
);

  logic [5:0] diff;
  logic       in_data;

  assign diff    = offset - DATA_BASE;
  assign in_data = (offset >= DATA_BASE) && (diff < {2'b00, cmd.count});

  always_comb begin
    case (offset)
      6'h00:   byte_out = SYNC_HI;
      6'h01:   byte_out = SYNC_LO;
      6'h02:   byte_out = cmd.big_endian ? crc[15:8] : crc[7:0];
      6'h03:   byte_out = cmd.big_endian ? crc[7:0] : crc[15:8];
      6'h04:   byte_out = PLEN_BASE + {4'h0, cmd.count};
      6'h0E:   byte_out = cmd.id[7:0];
      6'h0F:   byte_out = cmd.id[15:8];
      default: byte_out = in_data ? cmd.data[{diff[2:0], 3'b000} +: 8] : 8'h00;
    endcase
  end

endmodule

### src/crc16_command_frame_builder_top.sv
// sequence: an accepted command first runs the crc pass over offsets 4..17+n
//   (n = data count saturated to 8), then emits frame bytes 0..63, one byte per cycle
// a new command is taken only in idle; the crc pass runs in the byte-wide crc unit,
//   followed by the byte-by-byte emit counter, and busy covers both phases
// reset: synchronous, active high; returns to idle, any frame in flight is dropped
// the receiver cannot stall: each byte is on the ports for exactly one cycle
module crc16_command_frame_builder_top
  import cfb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] command_id,
  input  logic [3:0]  data_count,
  input  logic [63:0] data_bytes,
  input  logic        crc_big_endian,
  output logic        byte_valid,
  output logic [7:0]  frame_byte,
  output logic [5:0]  byte_offset,
  output logic        last_byte
);

  state_t      state, state_next;
  logic [5:0]  offset, offset_next;
  cmd_t        cmd;
  logic [15:0] crc;
  logic [7:0]  mux_byte;
  logic        accept;
  logic [5:0]  span_last;
  logic [3:0]  count_sat;

  assign accept    = start && (state == ST_IDLE);
  assign count_sat = (data_count > MAX_COUNT) ? MAX_COUNT : data_count;
  // last byte covered by the crc: length bytes plus id area plus data
  assign span_last = DATA_BASE - 6'd1 + {2'b00, cmd.count};

  // command register, loaded on the accepting transfer
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd.id         <= command_id;
      cmd.count      <= count_sat;
      cmd.data       <= data_bytes;
      cmd.big_endian <= crc_big_endian;
    end
  end

  // sequencer: crc pass over offsets 4..17+n, then emit pass over 0..63
  always_comb begin
    state_next  = state;
    offset_next = offset;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next  = ST_CRC;
          offset_next = SPAN_BASE;
        end
      end
      ST_CRC: begin
        if (offset == span_last) begin
          state_next  = ST_EMIT;
          offset_next = 6'd0;
        end else begin
          offset_next = offset + 6'd1;
        end
      end
      ST_EMIT: begin
        if (offset == LAST_OFF) begin
          state_next  = ST_IDLE;
          offset_next = 6'd0;
        end else begin
          offset_next = offset + 6'd1;
        end
      end
      default: begin
        state_next  = ST_IDLE;
        offset_next = 6'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      offset <= 6'd0;
    end else begin
      state  <= state_next;
      offset <= offset_next;
    end
  end

  // one frame byte generator shared by both passes; the crc bytes at
  // offsets 2 and 3 are only read during emit, after the crc is final
  cfb_byte_mux u_mux (
    .cmd      (cmd),
    .offset   (offset),
    .crc      (crc),
    .byte_out (mux_byte)
  );

  cfb_crc_unit u_crc (
    .clk  (clk),
    .init (accept),
    .en   (state == ST_CRC),
    .din  (mux_byte),
    .crc  (crc)
  );

  assign busy        = (state != ST_IDLE);
  assign byte_valid  = (state == ST_EMIT);
  assign frame_byte  = mux_byte;
  assign byte_offset = offset;
  assign last_byte   = (state == ST_EMIT) && (offset == LAST_OFF);

  // an accepted command makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transfer did not raise busy");

  // emitted offsets run in steps of one within a frame
  a_offset_step: assert property (@(posedge clk) disable iff (rst)
    byte_valid && !last_byte |=> byte_valid && (byte_offset == $past(byte_offset) + 6'd1))
    else $error("frame byte offsets not consecutive");

  // the frame ends with the last byte and the block goes idle
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    byte_valid && last_byte |=> !busy)
    else $error("block still busy after last byte");

  // the crc pass never reaches past the data area
  a_crc_span: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CRC) |-> (offset >= SPAN_BASE) && (offset <= span_last))
    else $error("crc pass outside its span");

endmodule

### tb/frame_checker.sv
`timescale 1ns / 100ps

module frame_checker
  import cfb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [15:0] command_id,
  input  logic [3:0]  data_count,
  input  logic [63:0] data_bytes,
  input  logic        crc_big_endian,
  input  logic        byte_valid,
  input  logic [7:0]  frame_byte,
  input  logic [5:0]  byte_offset,
  input  logic        last_byte,
  output int          mismatches,
  output int          outstanding
);

  localparam int PLEN_OFF  = 4;
  localparam int CRC_OFF   = 2;
  localparam int ID_OFF    = 'h0E;

  typedef struct packed {
    logic [7:0] value;
    logic [5:0] offset;
    logic       last;
  } frame_entry_t;

  frame_entry_t expected_bytes[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic logic [15:0] crc_ccitt_byte(input logic [15:0] acc, input logic [7:0] b);
    acc = acc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      acc = acc[15] ? ((acc << 1) ^ CRC_POLY) : (acc << 1);
    end
    return acc;
  endfunction

  // whole frame packed with offset i in bits 8i+7:8i
  function automatic logic [8*FRAME_BYTES-1:0] build_frame(input logic [15:0] id,
                                                           input logic [3:0]  count,
                                                           input logic [63:0] data,
                                                           input logic        be);
    logic [8*FRAME_BYTES-1:0] fr;
    logic [3:0]               n;
    logic [7:0]               plen;
    logic [15:0]              crc;
    int                       span_end;
    n  = (count > MAX_COUNT) ? MAX_COUNT : count;
    fr = '0;
    fr[7:0]  = SYNC_HI;
    fr[15:8] = SYNC_LO;
    plen = PLEN_BASE + 8'(n);
    fr[8*PLEN_OFF +: 8] = plen;
    fr[8*ID_OFF +: 8]       = id[7:0];
    fr[8*(ID_OFF+1) +: 8]   = id[15:8];
    for (int i = 0; i < int'(n); i++) begin
      fr[8*(int'(DATA_BASE)+i) +: 8] = data[8*i +: 8];
    end
    crc      = CRC_INIT;
    span_end = int'(SPAN_BASE) + int'(plen) + 2;
    for (int i = int'(SPAN_BASE); i < span_end && i < FRAME_BYTES; i++) begin
      crc = crc_ccitt_byte(crc, fr[8*i +: 8]);
    end
    if (be) begin
      fr[8*CRC_OFF +: 8]     = crc[15:8];
      fr[8*(CRC_OFF+1) +: 8] = crc[7:0];
    end else begin
      fr[8*CRC_OFF +: 8]     = crc[7:0];
      fr[8*(CRC_OFF+1) +: 8] = crc[15:8];
    end
    return fr;
  endfunction

  task automatic report(input string what, input int got, input int want);
    $display("%0t mismatch: %s got %0h expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    frame_entry_t             head;
    logic [8*FRAME_BYTES-1:0] fr;
    if (!rst) begin
      if (byte_valid) begin
        if (expected_bytes.size() == 0) begin
          report("unexpected byte at offset", int'(byte_offset), 0);
        end else begin
          head = expected_bytes.pop_front();
          if (byte_offset !== head.offset) begin
            report("byte_offset", int'(byte_offset), int'(head.offset));
          end
          if (frame_byte !== head.value) begin
            report("frame_byte", int'(frame_byte), int'(head.value));
          end
          if (last_byte !== head.last) begin
            report("last_byte", int'(last_byte), int'(head.last));
          end
        end
      end
      if (start && !busy) begin
        fr = build_frame(command_id, data_count, data_bytes, crc_big_endian);
        for (int i = 0; i < FRAME_BYTES; i++) begin
          head.value  = fr[8*i +: 8];
          head.offset = 6'(i);
          head.last   = (i == FRAME_BYTES - 1);
          expected_bytes.insert(expected_bytes.size(), head);
        end
      end
      outstanding = expected_bytes.size();
    end
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench
  import cfb_pkg::*;
;

  // a sender gap can be longer than the busy time of one command
  localparam int  RANDOM_PER_PHASE = 95;
  localparam int  MAX_GAP          = 100;
  localparam int  DRAIN_CYCLES     = 100;
  localparam time RUN_LIMIT        = 5_000_000;

  logic        clk            = 1'b0;
  logic        rst            = 1'b1;
  logic        start          = 1'b0;
  logic [15:0] command_id     = '0;
  logic [3:0]  data_count     = '0;
  logic [63:0] data_bytes     = '0;
  logic        crc_big_endian = 1'b0;
  logic        busy;
  logic        byte_valid;
  logic [7:0]  frame_byte;
  logic [5:0]  byte_offset;
  logic        last_byte;
  int          mismatches;
  int          outstanding;

  // sender idle percentage per phase: none, sender, receiver (cannot stall), both
  int          idle_pct[4] = '{0, 58, 0, 34};

  always #4 clk = ~clk;

  crc16_command_frame_builder_top dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .command_id     (command_id),
    .data_count     (data_count),
    .data_bytes     (data_bytes),
    .crc_big_endian (crc_big_endian),
    .byte_valid     (byte_valid),
    .frame_byte     (frame_byte),
    .byte_offset    (byte_offset),
    .last_byte      (last_byte)
  );

  // watches both sides, predicts every frame byte and compares
  frame_checker frame_check (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .command_id     (command_id),
    .data_count     (data_count),
    .data_bytes     (data_bytes),
    .crc_big_endian (crc_big_endian),
    .byte_valid     (byte_valid),
    .frame_byte     (frame_byte),
    .byte_offset    (byte_offset),
    .last_byte      (last_byte),
    .mismatches     (mismatches),
    .outstanding    (outstanding)
  );

  // called just after a falling edge; holds the command until a transfer
  // happens, returns just after the next falling edge with start still high
  task automatic send_command(input logic [15:0] id, input logic [3:0] n,
                              input logic [63:0] data, input logic be);
    command_id     = id;
    data_count     = n;
    data_bytes     = data;
    crc_big_endian = be;
    start          = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // random command: mostly legal counts, some that saturate, now and then
  // all-zero or all-one data so the unused bytes are exercised too
  task automatic send_random();
    logic [3:0]  n;
    logic [63:0] data;
    int          pick;
    n    = ($urandom_range(99) < 80) ? 4'($urandom_range(8)) : 4'($urandom_range(15, 9));
    pick = $urandom_range(9);
    if (pick == 0) data = '0;
    else if (pick == 1) data = '1;
    else data = {$urandom, $urandom};
    send_command(16'($urandom), n, data, 1'($urandom));
  endtask

  // sender gap of random length so it lands on every point of the crc and emit work;
  // the fields carry junk while start is low
  task automatic sender_gap(input int pct);
    if ($urandom_range(99) < pct) begin
      start          = 1'b0;
      command_id     = 16'($urandom);
      data_count     = 4'($urandom);
      data_bytes     = {$urandom, $urandom};
      crc_big_endian = 1'($urandom);
      repeat ($urandom_range(MAX_GAP, 1)) @(negedge clk);
    end
  endtask

  // lower start and hold off until every predicted byte has come out
  task automatic wait_drained();
    start = 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin
    // reset from time zero, released on a falling edge
    repeat (4) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // directed: id and data extremes, every count, both crc orders
    send_command(16'h0000, 4'd0, 64'h0, 1'b0);
    send_command(16'hFFFF, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_command(16'h1234, 4'd1, 64'h0000_0000_0000_00A5, 1'b0);
    send_command(16'hABCD, 4'd2, 64'h0000_0000_0000_5AFF, 1'b1);
    send_command(16'h8001, 4'd3, 64'h0000_0000_0012_3456, 1'b0);
    send_command(16'h7FFE, 4'd4, 64'h0000_0000_DEAD_BEEF, 1'b1);
    send_command(16'h00FF, 4'd5, 64'h0000_0001_0203_0405, 1'b0);
    send_command(16'hFF00, 4'd6, 64'h0000_8080_8080_8080, 1'b1);
    send_command(16'h5555, 4'd7, 64'h0011_2233_4455_6677, 1'b0);
    send_command(16'hAAAA, 4'd8, 64'h8899_AABB_CCDD_EEFF, 1'b1);
    send_command(16'hFFFF, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_command(16'h0000, 4'd8, 64'h0000_0000_0000_0000, 1'b1);
    // unused data bytes set: they must not leak into the frame
    send_command(16'h0F0F, 4'd3, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_command(16'hF0F0, 4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    // count too large saturates to eight bytes
    send_command(16'h1111, 4'd9, 64'h0123_4567_89AB_CDEF, 1'b0);
    send_command(16'h2222, 4'd12, 64'hFEDC_BA98_7654_3210, 1'b1);
    send_command(16'h3333, 4'd15, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_command(16'hFFFF, 4'd15, 64'h0, 1'b1);
    // pressure: sender holds off until the pipeline is empty
    wait_drained();
    @(negedge clk);

    // random phases with different sender idling
    for (int p = 0; p < 4; p++) begin
      for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
        send_random();
        sender_gap(idle_pct[p]);
      end
      wait_drained();
      @(negedge clk);
    end

    // all accepted and drained; leave room for any stray byte to show up
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("crc16_command_frame_builder_top test passed");
    end else begin
      $display("crc16_command_frame_builder_top test failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #(RUN_LIMIT);
    $display("crc16_command_frame_builder_top test failed");
    $finish;
  end

endmodule

### files.f
src/cfb_pkg.sv
src/cfb_crc_unit.sv
src/cfb_byte_mux.sv
src/crc16_command_frame_builder_top.sv
tb/frame_checker.sv
tb/testbench.sv
